// File: src/gdou_pkg.sv
// shared types, constants and calendar helper functions for the date offset unit
package gdou_pkg;

  localparam int YEARS_PER_CYCLE = 400;
  localparam int DAYS_PER_CYCLE  = 146097;
  localparam int RES_W           = 9;
  localparam int QUEUE_DEPTH     = 2;

  // year mod 400 is 16 * ((year >> 4) mod 25) + year[3:0]; the quotient by 25
  // comes from a reciprocal product, exact for any 28-bit dividend
  localparam int          QUO_W       = 24;
  localparam int          RECIP_SHIFT = 31;
  localparam logic [26:0] RECIP_25    = 27'd85899346;

  localparam logic [RES_W-1:0] RES_LAST = 9'd399;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_MAY = 4'd5;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_JUL = 4'd7;
  localparam logic [3:0] MONTH_AUG = 4'd8;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_OCT = 4'd10;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] LAST_DAY_DEC = 5'd31;
  localparam logic [4:0] FIRST_DAY    = 5'd1;

  // first day of january within a march-based year
  localparam logic [8:0] DOY_JAN = 9'd306;

  typedef enum logic [1:0] {
    ORD_EARLIER = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_LATER   = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_QUO,
    F_RES,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_WALK
  } back_state_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_BACK400,
    STEP_BACK1,
    STEP_FWD400,
    STEP_FWD1
  } step_t;

  // width of the signed day count carried through the walk
  function automatic int t_width(input int offset_bits);
    return ((offset_bits > 18) ? offset_bits : 18) + 2;
  endfunction

  // width of one queued command
  function automatic int cmd_width(input int year_bits, input int offset_bits);
    return 2 * year_bits + 23 + t_width(offset_bits);
  endfunction

  // leap test on the year residue modulo 400
  function automatic logic leap_res(input logic [RES_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [RES_W-1:0] res_inc(input logic [RES_W-1:0] r);
    return (r == RES_LAST) ? '0 : r + 9'd1;
  endfunction

  function automatic logic [RES_W-1:0] res_dec(input logic [RES_W-1:0] r);
    return (r == '0) ? RES_LAST : r - 9'd1;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC: d = 5'd31;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
      MONTH_FEB: d = leap ? 5'd29 : 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // day index of the first of a month, counted from march 1
  function automatic logic [8:0] march_cum(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      MONTH_MAR: c = 9'd0;
      MONTH_APR: c = 9'd31;
      MONTH_MAY: c = 9'd61;
      MONTH_JUN: c = 9'd92;
      MONTH_JUL: c = 9'd122;
      MONTH_AUG: c = 9'd153;
      MONTH_SEP: c = 9'd184;
      MONTH_OCT: c = 9'd214;
      MONTH_NOV: c = 9'd245;
      MONTH_DEC: c = 9'd275;
      MONTH_JAN: c = 9'd306;
      MONTH_FEB: c = 9'd337;
      default:   c = 9'd0;
    endcase
    return c;
  endfunction

  // month holding a day index of a march-based year
  function automatic logic [3:0] march_month(input logic [8:0] doy);
    logic [3:0] m;
    if (doy >= 9'd337) m = MONTH_FEB;
    else if (doy >= 9'd306) m = MONTH_JAN;
    else if (doy >= 9'd275) m = MONTH_DEC;
    else if (doy >= 9'd245) m = MONTH_NOV;
    else if (doy >= 9'd214) m = MONTH_OCT;
    else if (doy >= 9'd184) m = MONTH_SEP;
    else if (doy >= 9'd153) m = MONTH_AUG;
    else if (doy >= 9'd122) m = MONTH_JUL;
    else if (doy >= 9'd92) m = MONTH_JUN;
    else if (doy >= 9'd61) m = MONTH_MAY;
    else if (doy >= 9'd31) m = MONTH_APR;
    else m = MONTH_MAR;
    return m;
  endfunction

endpackage

// File: src/gdou_front.sv
// front end: accepts a date, finds year mod 400, validates, orders and queues a command
module gdou_front
  import gdou_pkg::*;
#(
  parameter int YEAR_BITS   = 16,
  parameter int OFFSET_BITS = 21
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [YEAR_BITS-1:0]                         in_year,
  input  logic [3:0]                                   in_month,
  input  logic [4:0]                                   in_day,
  input  logic signed [OFFSET_BITS-1:0]                day_offset,
  input  logic [YEAR_BITS-1:0]                         ref_year,
  input  logic [3:0]                                   ref_month,
  input  logic [4:0]                                   ref_day,
  output logic                                         cmd_push,
  output logic [cmd_width(YEAR_BITS,OFFSET_BITS)-1:0]  cmd,
  input  logic                                         cmd_full
);

  localparam int TW   = t_width(OFFSET_BITS);
  localparam int YW   = YEAR_BITS + 2;
  localparam int HI_W = 28;
  localparam int PW   = QUO_W + RECIP_SHIFT;

  typedef struct packed {
    logic                   ok;
    logic [1:0]             order;
    logic [YEAR_BITS-1:0]   y;
    logic [3:0]             m;
    logic [4:0]             d;
    logic signed [YW-1:0]   yq;
    logic [RES_W-1:0]       res;
    logic signed [TW-1:0]   t;
  } cmd_t;

  front_state_t state, state_next;

  logic [YEAR_BITS-1:0]          y_r, ry_r;
  logic [3:0]                    m_r, rm_r;
  logic [4:0]                    d_r, rd_r;
  logic signed [OFFSET_BITS-1:0] off_r;
  logic [RES_W-1:0]              res;
  logic [31:0]                   y_wide;
  logic [HI_W-1:0]               y_hi;
  logic [PW-1:0]                 prod;
  logic [QUO_W-1:0]              quo;
  logic [HI_W-1:0]               quo_x25;
  logic [4:0]                    rem25;

  logic       early;
  logic [4:0] mlen;
  logic [8:0] doy;
  order_t     order;
  logic signed [TW-1:0] off_ext;
  cmd_t       c;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (in_valid) state_next = F_QUO;
      F_QUO:  state_next = F_RES;
      F_RES:  state_next = F_PUSH;
      F_PUSH: if (!cmd_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd_push = 1'b0;
    case (state)
      F_IDLE: in_ready = 1'b1;
      F_PUSH: cmd_push = !cmd_full;
      default: begin
        in_ready = 1'b0;
        cmd_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      y_r   <= in_year;
      m_r   <= in_month;
      d_r   <= in_day;
      off_r <= day_offset;
      ry_r  <= ref_year;
      rm_r  <= ref_month;
      rd_r  <= ref_day;
    end
  end

  // year residue: quotient of year/16 by 25 registered in F_QUO, remainder in F_RES right after it
  assign y_wide  = 32'(y_r);
  assign y_hi    = y_wide[31:4];
  assign prod    = PW'(y_hi) * PW'(RECIP_25);
  assign quo_x25 = HI_W'(quo) * HI_W'(25);
  assign rem25   = 5'(y_hi - quo_x25);

  always_ff @(posedge clk) begin
    if (state == F_QUO) begin
      quo <= prod[PW-1:RECIP_SHIFT];
    end
    if (state == F_RES) begin
      res <= {rem25, y_wide[3:0]};
    end
  end

  // classification
  always_comb begin
    if (y_r != ry_r) order = (y_r > ry_r) ? ORD_LATER : ORD_EARLIER;
    else if (m_r != rm_r) order = (m_r > rm_r) ? ORD_LATER : ORD_EARLIER;
    else if (d_r != rd_r) order = (d_r > rd_r) ? ORD_LATER : ORD_EARLIER;
    else order = ORD_EQUAL;
  end

  assign early   = (m_r < MONTH_MAR);
  assign mlen    = month_days(m_r, leap_res(res));
  assign doy     = march_cum(m_r) + 9'(d_r) - 9'd1;
  assign off_ext = {{(TW-OFFSET_BITS){off_r[OFFSET_BITS-1]}}, off_r};

  always_comb begin
    c.ok    = (m_r >= MONTH_JAN) && (m_r <= MONTH_DEC) && (d_r >= FIRST_DAY) && (d_r <= mlen);
    c.order = order;
    c.y     = y_r;
    c.m     = m_r;
    c.d     = d_r;
    c.yq    = YW'({2'b00, y_r}) - YW'(early);
    c.res   = early ? res_dec(res) : res;
    c.t     = TW'(doy) + off_ext;
  end

  assign cmd = c;

endmodule

// File: src/gdou_queue.sv
// two-entry command queue between the front and back ends
module gdou_queue
  import gdou_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    count;

  assign full      = (count == NW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) count <= count + NW'(1);
      else if (pop && !push) count <= count - NW'(1);
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");

endmodule

// File: src/gdou_back.sv
// back end: walks the day count by four-century and one-year steps, then splits the date
module gdou_back
  import gdou_pkg::*;
#(
  parameter int YEAR_BITS   = 16,
  parameter int OFFSET_BITS = 21
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cmd_valid,
  output logic                                         cmd_pop,
  input  logic [cmd_width(YEAR_BITS,OFFSET_BITS)-1:0]  cmd,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [YEAR_BITS-1:0]                         out_year,
  output logic [3:0]                                   out_month,
  output logic [4:0]                                   out_day,
  output logic                                         date_valid,
  output logic                                         range_saturated,
  output logic [1:0]                                   order_code
);

  localparam int TW = t_width(OFFSET_BITS);
  localparam int YW = YEAR_BITS + 2;

  typedef struct packed {
    logic                   ok;
    logic [1:0]             order;
    logic [YEAR_BITS-1:0]   y;
    logic [3:0]             m;
    logic [4:0]             d;
    logic signed [YW-1:0]   yq;
    logic [RES_W-1:0]       res;
    logic signed [TW-1:0]   t;
  } cmd_t;

  localparam logic signed [YW-1:0] YQ_NEG1    = '1;
  localparam logic signed [YW-1:0] YQ_400     = YW'(YEARS_PER_CYCLE);
  localparam logic signed [YW-1:0] YQ_399     = YW'(YEARS_PER_CYCLE - 1);
  localparam logic signed [YW-1:0] YQ_MAX     = {2'b00, {YEAR_BITS{1'b1}}};
  localparam logic signed [YW-1:0] YQ_MAXM400 = YQ_MAX - YQ_400;
  localparam logic signed [TW-1:0] T_400      = TW'(DAYS_PER_CYCLE);
  localparam logic signed [TW-1:0] T_NEG400   = -T_400;
  localparam logic signed [TW-1:0] T_JAN      = TW'(DOY_JAN);

  back_state_t state, state_next;
  cmd_t        cmd_in, c;

  logic signed [YW-1:0] yq;
  logic [RES_W-1:0]     res;
  logic signed [TW-1:0] t;

  logic signed [TW-1:0] len_cur_s, len_prev_s;
  logic                 at_low, at_high, neg;
  logic                 done, sat_lo, sat_hi, slot_free, load_out;
  step_t                step;

  logic [8:0]           doy;
  logic [3:0]           mon;
  logic [4:0]           day;
  logic signed [YW-1:0] yr_adj;

  assign cmd_in = cmd;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (cmd_valid) state_next = B_WALK;
      B_WALK: if (done && slot_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    load_out = 1'b0;
    case (state)
      B_IDLE: cmd_pop = cmd_valid;
      B_WALK: load_out = done && slot_free;
      default: begin
        cmd_pop  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // march-based year yq spans march 1 of yq to february of yq+1
  assign len_cur_s  = TW'(9'd365 + 9'(leap_res(res_inc(res))));
  assign len_prev_s = TW'(9'd365 + 9'(leap_res(res)));
  assign at_low     = (yq == YQ_NEG1);
  assign at_high    = (yq == YQ_MAX);
  assign neg        = t[TW-1];
  assign slot_free  = !out_valid || out_ready;

  always_comb begin
    step   = STEP_NONE;
    done   = 1'b0;
    sat_lo = 1'b0;
    sat_hi = 1'b0;
    if (!c.ok) begin
      done = 1'b1;
    end else if (neg) begin
      if (at_low) begin
        done   = 1'b1;
        sat_lo = 1'b1;
      end else if ((t <= T_NEG400) && (yq >= YQ_399)) begin
        step = STEP_BACK400;
      end else begin
        step = STEP_BACK1;
      end
    end else if (t >= len_cur_s) begin
      if (at_high) begin
        done   = 1'b1;
        sat_hi = 1'b1;
      end else if ((t >= T_400) && (yq <= YQ_MAXM400)) begin
        step = STEP_FWD400;
      end else begin
        step = STEP_FWD1;
      end
    end else begin
      done   = 1'b1;
      sat_lo = at_low && (t < T_JAN);
      sat_hi = at_high && (t >= T_JAN);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      c   <= cmd_in;
      yq  <= cmd_in.yq;
      res <= cmd_in.res;
      t   <= cmd_in.t;
    end else if (state == B_WALK) begin
      case (step)
        STEP_BACK400: begin
          yq <= yq - YQ_400;
          t  <= t + T_400;
        end
        STEP_BACK1: begin
          yq  <= yq - YW'(1);
          t   <= t + len_prev_s;
          res <= res_dec(res);
        end
        STEP_FWD400: begin
          yq <= yq + YQ_400;
          t  <= t - T_400;
        end
        STEP_FWD1: begin
          yq  <= yq + YW'(1);
          t   <= t - len_cur_s;
          res <= res_inc(res);
        end
        default: begin
          yq <= yq;
        end
      endcase
    end
  end

  // split the day index into month and day
  assign doy    = t[8:0];
  assign mon    = march_month(doy);
  assign day    = 5'(doy - march_cum(mon) + 9'd1);
  assign yr_adj = yq + YW'(mon < MONTH_MAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      order_code <= c.order;
      date_valid <= c.ok;
      if (!c.ok) begin
        out_year        <= c.y;
        out_month       <= c.m;
        out_day         <= c.d;
        range_saturated <= 1'b0;
      end else if (sat_lo) begin
        out_year        <= '0;
        out_month       <= MONTH_JAN;
        out_day         <= FIRST_DAY;
        range_saturated <= 1'b1;
      end else if (sat_hi) begin
        out_year        <= '1;
        out_month       <= MONTH_DEC;
        out_day         <= LAST_DAY_DEC;
        range_saturated <= 1'b1;
      end else begin
        out_year        <= yr_adj[YEAR_BITS-1:0];
        out_month       <= mon;
        out_day         <= day;
        range_saturated <= 1'b0;
      end
    end
  end

  a_year_in_range : assert property (@(posedge clk) disable iff (rst)
      (state == B_WALK && c.ok) |-> (yq >= YQ_NEG1 && yq <= YQ_MAX))
    else $error("walk year left the representable range");
  a_sat_needs_valid : assert property (@(posedge clk) disable iff (rst)
      (out_valid && range_saturated) |-> date_valid)
    else $error("saturation flagged on an invalid date");

endmodule

// File: src/gregorian_date_offset_unit.sv
// top level of the gregorian date offset unit: stream ports, front end, queue, back end
// path from accept to m_axis_tvalid: the front end's quotient, residue and queue write states,
//   then the back end's walk of N400 four-century steps (about |offset|/146097) and
//   N1 <= 400 single-year steps, one step per cycle, plus output stalls
// overlap: each end takes a new item only once idle again, the queue overlaps the two ends
// reset: rst clears the front and back state machines, the queue pointers and m_axis_tvalid
module gregorian_date_offset_unit
  import gdou_pkg::*;
#(
  parameter int YEAR_BITS   = 16,
  parameter int OFFSET_BITS = 21
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // fields from bit 0: in_year, in_month, in_day, day_offset, ref_year, ref_month,
  // ref_day, zero padding
  input  logic [((2*YEAR_BITS+18+OFFSET_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // fields from bit 0: out_year, out_month, out_day, date_valid, range_saturated,
  // order_code, zero padding
  output logic [((YEAR_BITS+13+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CMD_W  = cmd_width(YEAR_BITS, OFFSET_BITS);
  localparam int OUT_W  = YEAR_BITS + 13;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  // input field positions
  localparam int P_MON  = YEAR_BITS;
  localparam int P_DAY  = P_MON + 4;
  localparam int P_OFF  = P_DAY + 5;
  localparam int P_RY   = P_OFF + OFFSET_BITS;
  localparam int P_RM   = P_RY + YEAR_BITS;
  localparam int P_RD   = P_RM + 4;

  logic [YEAR_BITS-1:0]          in_year, ref_year;
  logic [3:0]                    in_month, ref_month;
  logic [4:0]                    in_day, ref_day;
  logic signed [OFFSET_BITS-1:0] day_offset;

  logic             cmd_push, cmd_full, cmd_pop, cmd_valid;
  logic [CMD_W-1:0] cmd_wr, cmd_rd;

  logic [YEAR_BITS-1:0] out_year;
  logic [3:0]           out_month;
  logic [4:0]           out_day;
  logic                 date_valid, range_saturated;
  logic [1:0]           order_code;
  logic [OUT_W-1:0]     out_packed;

  assign in_year    = s_axis_tdata[P_MON-1:0];
  assign in_month   = s_axis_tdata[P_DAY-1:P_MON];
  assign in_day     = s_axis_tdata[P_OFF-1:P_DAY];
  assign day_offset = s_axis_tdata[P_RY-1:P_OFF];
  assign ref_year   = s_axis_tdata[P_RM-1:P_RY];
  assign ref_month  = s_axis_tdata[P_RD-1:P_RM];
  assign ref_day    = s_axis_tdata[P_RD+4:P_RD];

  // front end: residue of the year, validity, ordering, march-based day count
  gdou_front #(
    .YEAR_BITS   (YEAR_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .day_offset (day_offset),
    .ref_year   (ref_year),
    .ref_month  (ref_month),
    .ref_day    (ref_day),
    .cmd_push   (cmd_push),
    .cmd        (cmd_wr),
    .cmd_full   (cmd_full)
  );

  // decouples the two ends so each can stall on its own
  gdou_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .wr_data   (cmd_wr),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .rd_data   (cmd_rd),
    .not_empty (cmd_valid)
  );

  // back end: year walk, clamping and result register
  gdou_back #(
    .YEAR_BITS   (YEAR_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop),
    .cmd             (cmd_rd),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .date_valid      (date_valid),
    .range_saturated (range_saturated),
    .order_code      (order_code)
  );

  assign out_packed   = {order_code, range_saturated, date_valid, out_day, out_month, out_year};
  assign m_axis_tdata = OUT_TW'(out_packed);

endmodule
